>>> rtl/spa_pkg.sv
// Package with widths, reset constants and shared types of the sine peak detector.
`default_nettype none
package spa_pkg;

  localparam int ValueW  = 12;
  localparam int TimeW   = 12;
  localparam int ChanW   = 3;
  localparam int AmpW    = 11;
  localparam int OffsetW = 13;

  localparam logic [ValueW-1:0] MaxReload   = '0;
  localparam logic [ValueW-1:0] MinReload   = 12'hFFF;
  localparam logic [TimeW-1:0]  TimeReload  = '0;
  localparam logic [TimeW-1:0]  PeriodReset = 12'hFFF;
  localparam logic [ChanW-1:0]  RefChannel  = '0;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [TimeW-1:0]  stamp;
    logic [ChanW-1:0]  chan;
    logic              last;
  } spa_sample_t;

  typedef struct packed {
    logic [ValueW-1:0] run_max;
    logic [ValueW-1:0] run_min;
    logic [TimeW-1:0]  peak_stamp;
  } frame_stats_t;

  typedef struct packed {
    logic             load;
    logic [ChanW-1:0] chan;
  } result_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/spa_if.sv
// Stream interfaces for the sample input and the result output channels.
`default_nettype none
interface spa_in_if import spa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] sample_value;
  logic [TimeW-1:0]  sample_time;
  logic [ChanW-1:0]  channel_index;
  logic              last_sample;

  modport source (
    output valid, sample_value, sample_time, channel_index, last_sample,
    input  ready
  );
  modport sink (
    input  valid, sample_value, sample_time, channel_index, last_sample,
    output ready
  );
endinterface

interface spa_out_if import spa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [AmpW-1:0]    amplitude;
  logic [OffsetW-1:0] phase_offset;

  modport source (
    output valid, amplitude, phase_offset,
    input  ready
  );
  modport sink (
    input  valid, amplitude, phase_offset,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/spa_tracker.sv
// Running maximum, minimum and time-of-maximum tracker over one frame.
`default_nettype none
module spa_tracker import spa_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire spa_sample_t  smp_i,
  input  wire logic         adv_i,
  output frame_stats_t      stats_o
);

  frame_stats_t stats_q;
  frame_stats_t stats_d;

  // Stats of the frame including the sample held in the input register.
  always_comb begin
    stats_d = stats_q;
    if (smp_i.value > stats_q.run_max) begin
      stats_d.run_max    = smp_i.value;
      stats_d.peak_stamp = smp_i.stamp;
    end
    if (smp_i.value < stats_q.run_min) begin
      stats_d.run_min = smp_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q.run_max    <= MaxReload;
      stats_q.run_min    <= MinReload;
      stats_q.peak_stamp <= TimeReload;
    end else if (adv_i) begin
      if (smp_i.last) begin
        stats_q.run_max    <= MaxReload;
        stats_q.run_min    <= MinReload;
        stats_q.peak_stamp <= TimeReload;
      end else begin
        stats_q <= stats_d;
      end
    end
  end

  assign stats_o = stats_d;

endmodule
`default_nettype wire

>>> rtl/spa_result.sv
// Amplitude and phase offset logic with the reference time and the result register.
`default_nettype none
module spa_result import spa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire result_ctrl_t       ctrl_i,
  input  wire frame_stats_t       stats_i,
  input  wire logic [TimeW-1:0]   period_i,
  input  wire logic               out_ready_i,
  output logic                    can_load_o,
  output logic                    out_valid_o,
  output logic [AmpW-1:0]         amplitude_o,
  output logic [OffsetW-1:0]      phase_offset_o
);

  logic [TimeW-1:0]   ref_q;
  logic [TimeW-1:0]   ref_d;
  logic               valid_q;
  logic [AmpW-1:0]    amp_q;
  logic [OffsetW-1:0] offs_q;
  logic [OffsetW-1:0] offs_d;
  logic [ValueW-1:0]  span;

  assign span = stats_i.run_max - stats_i.run_min;

  // Reference channel, or a maximum at the reference time, gives zero and
  // rewrites the reference. An earlier maximum wraps by one signal period.
  always_comb begin
    ref_d  = ref_q;
    offs_d = '0;
    if (ctrl_i.chan == RefChannel || stats_i.peak_stamp == ref_q) begin
      ref_d = stats_i.peak_stamp;
    end else if (stats_i.peak_stamp > ref_q) begin
      offs_d = {1'b0, stats_i.peak_stamp - ref_q};
    end else begin
      offs_d = {1'b0, stats_i.peak_stamp} + {1'b0, period_i} - {1'b0, ref_q};
    end
  end

  assign can_load_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= TimeReload;
      valid_q <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        ref_q   <= ref_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      amp_q  <= span[ValueW-1:1];
      offs_q <= offs_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign amplitude_o    = amp_q;
  assign phase_offset_o = offs_q;

`ifndef SYNTH
  a_ref_chan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.load && ctrl_i.chan == RefChannel) |=> (phase_offset_o == '0))
    else $error("reference channel result has a nonzero phase offset");

  a_ref_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.load |=> $stable(ref_q))
    else $error("reference time changed without a result");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load |=> out_valid_o)
    else $error("result loaded but not presented");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load |-> can_load_o)
    else $error("result register overwritten while stalled");
`endif

endmodule
`default_nettype wire

>>> rtl/sine_peak_amplitude_phase.sv
// Top level of the sine peak amplitude and phase offset detector.
//
// Usage: samples of one frame arrive on sample_i, one transaction per sample,
// each with value, timestamp, channel number and a last flag. The block
// tracks the running maximum (with its timestamp) and the running minimum.
// The transaction that carries the last flag produces one transaction on
// result_o with the amplitude, (max - min) / 2, and the phase offset of the
// frame's maximum against the stored maximum time of the reference channel 0.
// Samples without the last flag produce no result.
// Each accepted sample is held in an input register, then the compare,
// subtract and offset logic writes the result register, which offers the
// result once the last sample has left the input register. One sample is
// taken in every cycle while sample_i.ready is high; the input register and
// the result register part the two sides, so samples keep flowing while a
// result waits. Only a last sample that finds the result register still
// occupied holds the input register, and then sample_i.ready drops until the
// receiver takes the result. The user must write the period register through
// cfg_we_i and cfg_wdata_i only while the block is idle; the block itself
// does not enforce this. Reset sets the period to 4095 ticks, the reference
// time to zero, reloads the running values and empties both registers.
`default_nettype none
module sine_peak_amplitude_phase import spa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TimeW-1:0]  cfg_wdata_i,
  spa_in_if.sink                 sample_i,
  spa_out_if.source              result_o
);

  logic [TimeW-1:0] period_q;
  logic             s1_valid_q;
  spa_sample_t      s1_q;
  logic             advance;
  logic             can_load;
  result_ctrl_t     ctrl;
  frame_stats_t     stats;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // A sample without the last flag always leaves the input register; a last
  // sample leaves only when the result register can take its result.
  assign advance        = s1_valid_q && (!s1_q.last || can_load);
  assign sample_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      s1_q.value <= sample_i.sample_value;
      s1_q.stamp <= sample_i.sample_time;
      s1_q.chan  <= sample_i.channel_index;
      s1_q.last  <= sample_i.last_sample;
    end
  end

  assign ctrl.load = advance && s1_q.last;
  assign ctrl.chan = s1_q.chan;

  spa_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .smp_i   (s1_q),
    .adv_i   (advance),
    .stats_o (stats)
  );

  spa_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stats_i        (stats),
    .period_i       (period_q),
    .out_ready_i    (result_o.ready),
    .can_load_o     (can_load),
    .out_valid_o    (result_o.valid),
    .amplitude_o    (result_o.amplitude),
    .phase_offset_o (result_o.phase_offset)
  );

endmodule
`default_nettype wire
